### rtl/tbpo_pkg.sv
// Shared types and constants for the timer bank.
// Holds the request and response word layouts, operation and status codes.
// Depends on nothing; every other file of the block but the slot memory uses it.
package tbpo_pkg;

   localparam int TIMER_COUNT_DEF = 16;
   localparam int TIME_WIDTH_DEF  = 32;

   localparam int CSR_WIDTH     = 32;
   localparam int ELAPSED_WIDTH = 16;

   typedef enum logic [2:0] {
      OP_START      = 3'd0,
      OP_SET_PAUSE  = 3'd1,
      OP_READ_TICK  = 3'd2,
      OP_READ_PAUSE = 3'd3,
      OP_ADVANCE    = 3'd4
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_TIMER = 2'd1;
   localparam logic [1:0] ST_SHORT    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]               operation;
      logic [3:0]               timer_id;
      logic [31:0]              interval;
      logic                     one_shot;
      logic                     pause_value;
      logic [ELAPSED_WIDTH-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] new_id;
      logic       ticked;
      logic       is_paused;
   } rsp_type;

endpackage

### rtl/tbpo_slot_ram.sv
// Simple dual-port slot memory holding per-timer flags, period and remaining count.
// One write and one registered read per cycle; contents are not reset.
// Depends on nothing outside this file.
module tbpo_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 67,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tbpo_mod_unit.sv
// Bit-serial remainder unit: one restoring step per cycle over the dividend.
// Computes dividend modulo divisor for a 16-bit dividend.
// Depends on tbpo_pkg for the dividend width.
module tbpo_mod_unit #(
   parameter int TIME_WIDTH = tbpo_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tbpo_pkg::ELAPSED_WIDTH-1:0] dividend,
   input  logic [TIME_WIDTH-1:0]              divisor,
   output logic                               done,
   output logic [TIME_WIDTH-1:0]              remainder
);

   localparam int DW  = tbpo_pkg::ELAPSED_WIDTH;
   localparam int CNW = $clog2(DW + 1);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [CNW-1:0]        count_ff, count_in;
   logic [DW-1:0]         dvd_ff, dvd_in;
   logic [TIME_WIDTH-1:0] rem_ff, rem_in;
   logic [TIME_WIDTH-1:0] div_ff, div_in;
   logic [TIME_WIDTH:0]   trial;
   logic [TIME_WIDTH:0]   diff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      trial     = {rem_ff, dvd_ff[DW-1]};
      diff      = trial - {1'b0, div_ff};
      if (start) begin
         active_in = 1'b1;
         count_in  = CNW'(DW);
         dvd_in    = dividend;
         rem_in    = '0;
         div_in    = divisor;
      end else if (active_ff) begin
         // The partial remainder stays below the divisor, so it fits the time width.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[TIME_WIDTH-1:0];
         end else begin
            rem_in = trial[TIME_WIDTH-1:0];
         end
         dvd_in   = {dvd_ff[DW-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == CNW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/timer_bank_periodic_oneshot_unit.sv
// Timer bank top level: sequencer, slot valid bits, configuration register.
// Depends on tbpo_pkg, tbpo_slot_ram and tbpo_mod_unit.
// A start word is answered from the operation state; pause and tick words for a known timer read the slot
// memory first and answer from the execute state. Advance visits every slot in turn, reads and evaluates each
// valid one, and if it overran a nonzero period waits on the shared bit-serial remainder unit to reload it.
// Busy stays high until the response strobe; one word in flight at a time, no output stall.
// Reset clears valid bits, the next-slot counter and sets min_interval to 1; memory is not swept.
module timer_bank_periodic_oneshot_unit #(
   parameter int TIMER_COUNT = tbpo_pkg::TIMER_COUNT_DEF,
   parameter int TIME_WIDTH  = tbpo_pkg::TIME_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tbpo_pkg::req_type              req_word,
   output logic                           rsp_valid,
   output tbpo_pkg::rsp_type              rsp_word,
   input  logic                           csr_wr_en,
   input  logic [tbpo_pkg::CSR_WIDTH-1:0] csr_wr_data
);

   // Slot index width, counter width (it must hold TIMER_COUNT itself) and compare width.
   localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int NW = $clog2(TIMER_COUNT + 1);
   localparam int CW = (TIME_WIDTH > tbpo_pkg::ELAPSED_WIDTH) ? TIME_WIDTH
                                                               : tbpo_pkg::ELAPSED_WIDTH;
   localparam int EW = 2 * TIME_WIDTH + 3;

   // Entry layout in the slot memory: {one_shot, paused, tick, period, remaining}.
   localparam int TICK_BIT   = 2 * TIME_WIDTH;
   localparam int PAUSE_BIT  = 2 * TIME_WIDTH + 1;
   localparam int ONESHOT_BIT = 2 * TIME_WIDTH + 2;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_OP      = 6'b000010,
      S_EXEC    = 6'b000100,
      S_SCAN_RD = 6'b001000,
      S_SCAN_EV = 6'b010000,
      S_SCAN_DV = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   tbpo_pkg::req_type          req_ff, req_in;
   logic [IW-1:0]              scan_ff, scan_in;
   logic [NW-1:0]              next_slot_ff, next_slot_in;
   logic [TIMER_COUNT-1:0]     valid_ff, valid_in;
   logic [tbpo_pkg::CSR_WIDTH-1:0] min_ff, min_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tbpo_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       ram_wr_en, ram_rd_en;
   logic [IW-1:0]              ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]              ram_wr_data, ram_rd_data;

   logic                       mod_start, mod_done;
   logic [tbpo_pkg::ELAPSED_WIDTH-1:0] mod_dvd;
   logic [TIME_WIDTH-1:0]      mod_rem;

   logic [8:0]                 id_ext, ns_ext;
   logic [IW-1:0]              id_idx;
   logic                       id_known;
   logic [63:0]                iv_ext, min_ext;
   logic [TIME_WIDTH-1:0]      iv_tw, min_tw;
   logic [TIME_WIDTH-1:0]      e_rem, e_per;
   logic                       e_tick, e_paused, e_one_shot;
   logic [CW-1:0]              el_cw, rem_cw, d_cw;
   logic                       scan_last, step_next;

   tbpo_slot_ram #(
      .DEPTH  (TIMER_COUNT),
      .DATA_W (EW),
      .ADDR_W (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tbpo_mod_unit #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (e_per),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Field views of the request and of the entry last read from memory.
   assign id_ext   = 9'(req_ff.timer_id);
   assign id_idx   = id_ext[IW-1:0];
   assign id_known = (id_ext < 9'(TIMER_COUNT)) && valid_ff[id_idx];
   assign ns_ext   = 9'(next_slot_ff);
   assign iv_ext   = 64'(req_ff.interval);
   assign min_ext  = 64'(min_ff);
   assign iv_tw    = iv_ext[TIME_WIDTH-1:0];
   assign min_tw   = min_ext[TIME_WIDTH-1:0];

   assign e_rem      = ram_rd_data[TIME_WIDTH-1:0];
   assign e_per      = ram_rd_data[2*TIME_WIDTH-1:TIME_WIDTH];
   assign e_tick     = ram_rd_data[TICK_BIT];
   assign e_paused   = ram_rd_data[PAUSE_BIT];
   assign e_one_shot = ram_rd_data[ONESHOT_BIT];

   // The overshoot past zero is below the elapsed amount, so 16 bits carry it.
   assign el_cw   = CW'(req_ff.elapsed);
   assign rem_cw  = CW'(e_rem);
   assign d_cw    = el_cw - rem_cw;
   assign mod_dvd = d_cw[tbpo_pkg::ELAPSED_WIDTH-1:0];

   assign scan_last = (scan_ff == IW'(TIMER_COUNT - 1));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      next_slot_in = next_slot_ff;
      valid_in     = valid_ff;
      min_in       = min_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = id_idx;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = id_idx;
      mod_start    = 1'b0;
      step_next    = 1'b0;

      if (csr_wr_en) begin
         min_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = S_OP;
            end
         end

         S_OP: begin
            rsp_in = '{status: tbpo_pkg::ST_OK, new_id: 4'd0, ticked: 1'b0, is_paused: 1'b0};
            case (req_ff.operation)
               tbpo_pkg::OP_START: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (next_slot_ff == NW'(TIMER_COUNT)) begin
                     rsp_in.status = tbpo_pkg::ST_FULL;
                  end else if (iv_tw < min_tw) begin
                     rsp_in.status = tbpo_pkg::ST_SHORT;
                  end else begin
                     // A new timer starts running, unpaused, with its full period to go.
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = ns_ext[IW-1:0];
                     ram_wr_data  = {req_ff.one_shot, 1'b0, 1'b0, iv_tw, iv_tw};
                     valid_in[ns_ext[IW-1:0]] = 1'b1;
                     next_slot_in = next_slot_ff + 1'b1;
                     rsp_in.new_id = ns_ext[3:0];
                  end
               end
               tbpo_pkg::OP_SET_PAUSE, tbpo_pkg::OP_READ_TICK, tbpo_pkg::OP_READ_PAUSE: begin
                  if (id_known) begin
                     ram_rd_en = 1'b1;
                     state_in  = S_EXEC;
                  end else begin
                     rsp_in.status = tbpo_pkg::ST_NO_TIMER;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               tbpo_pkg::OP_ADVANCE: begin
                  scan_in  = '0;
                  state_in = S_SCAN_RD;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end

         S_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (req_ff.operation)
               tbpo_pkg::OP_SET_PAUSE: begin
                  ram_wr_en              = 1'b1;
                  ram_wr_data[PAUSE_BIT] = req_ff.pause_value;
               end
               tbpo_pkg::OP_READ_TICK: begin
                  // A paused timer keeps its pending tick; a consumed one-shot is retired.
                  if (!e_paused && e_tick) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_data[TICK_BIT] = 1'b0;
                     rsp_in.ticked         = 1'b1;
                     if (e_one_shot) begin
                        valid_in[id_idx] = 1'b0;
                     end
                  end
               end
               tbpo_pkg::OP_READ_PAUSE: begin
                  rsp_in.is_paused = e_paused;
               end
               default: begin
               end
            endcase
         end

         S_SCAN_RD: begin
            ram_rd_addr = scan_ff;
            if (valid_ff[scan_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_SCAN_EV;
            end else begin
               step_next = 1'b1;
            end
         end

         S_SCAN_EV: begin
            ram_wr_addr = scan_ff;
            if (e_paused) begin
               step_next = 1'b1;
            end else if (el_cw <= rem_cw) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {e_one_shot, e_paused, e_tick, e_per, e_rem - TIME_WIDTH'(el_cw)};
               step_next   = 1'b1;
            end else if (e_per == '0) begin
               // A zero period pins the count at zero instead of reloading.
               ram_wr_en   = 1'b1;
               ram_wr_data = {e_one_shot, e_paused, 1'b1, e_per, {TIME_WIDTH{1'b0}}};
               step_next   = 1'b1;
            end else begin
               mod_start = 1'b1;
               state_in  = S_SCAN_DV;
            end
         end

         S_SCAN_DV: begin
            ram_wr_addr = scan_ff;
            if (mod_done) begin
               ram_wr_en = 1'b1;
               if (mod_rem == '0) begin
                  ram_wr_data = {e_one_shot, e_paused, 1'b1, e_per, {TIME_WIDTH{1'b0}}};
               end else begin
                  ram_wr_data = {e_one_shot, e_paused, 1'b1, e_per, e_per - mod_rem};
               end
               step_next = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Move the advance scan to the next slot, or finish once the last one is done.
      if (step_next) begin
         if (scan_last) begin
            rsp_in       = '{status: tbpo_pkg::ST_OK, new_id: 4'd0, ticked: 1'b0,
                             is_paused: 1'b0};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            scan_in  = scan_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_slot_ff <= '0;
         valid_ff     <= '0;
         min_ff       <= tbpo_pkg::CSR_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         next_slot_ff <= next_slot_in;
         valid_ff     <= valid_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/tbpo_checker.sv
// Port-level checks for the timer bank, bound to the top level.
// Depends on tbpo_pkg and timer_bank_periodic_oneshot_unit.
module tbpo_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tbpo_pkg::rsp_type rsp_word,
   input logic              rsp_valid
);

   // A taken word keeps the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a word was taken");

   // The response is only shown once the sequencer is back at rest.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // A taken word passes through the operation state first, so strobes never come back to back.
   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   // A failed operation returns no id, tick or pause data.
   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status != tbpo_pkg::ST_OK)) |->
         ((rsp_word.new_id == 4'd0) && !rsp_word.ticked && !rsp_word.is_paused))
      else $error("error response carries data");

endmodule

bind timer_bank_periodic_oneshot_unit tbpo_checker u_tbpo_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_word  (rsp_word),
   .rsp_valid (rsp_valid)
);

### verif/tbpo_answer_check.sv
// Response checker for the timer bank: predicts every response word and compares it.
// Watches the request, response and register ports of the block beside it.
// Depends on tbpo_pkg for the word layouts, operation and status codes.
module tbpo_answer_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  tbpo_pkg::req_type              req_word,
   input  logic                           rsp_valid,
   input  tbpo_pkg::rsp_type              rsp_word,
   input  logic                           csr_wr_en,
   input  logic [tbpo_pkg::CSR_WIDTH-1:0] csr_wr_data,
   output int                             fail_count,
   output int                             pending_words,
   output int                             words_checked,
   output int                             ticks_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbpo_pkg::*;

   localparam int SLOTS = TIMER_COUNT_DEF;

   logic        slot_live   [SLOTS];
   logic        slot_single [SLOTS];
   logic        slot_held   [SLOTS];
   logic        slot_tick   [SLOTS];
   logic [31:0] slot_period [SLOTS];
   logic [31:0] slot_left   [SLOTS];
   logic [4:0]  next_free;
   logic [31:0] min_interval;
   rsp_type     answer_q [$];

   // Counts a running timer down; on overrun flags a tick, reloads by a nonzero period.
   function automatic void age_slot(int s, logic [ELAPSED_WIDTH-1:0] el);
      logic [31:0] over;
      if ({16'd0, el} <= slot_left[s]) begin
         slot_left[s] = slot_left[s] - el;
      end else begin
         over = el - slot_left[s];
         slot_tick[s] = 1'b1;
         if (slot_period[s] == 0) begin
            slot_left[s] = '0;
         end else begin
            slot_left[s] = (slot_period[s] - over % slot_period[s]) % slot_period[s];
         end
      end
   endfunction

   function automatic rsp_type predict_answer(req_type w);
      rsp_type r;
      int      id;
      r  = '0;
      id = w.timer_id;
      case (w.operation)
         OP_START: begin
            if (next_free >= SLOTS) begin
               r.status = ST_FULL;
            end else if (w.interval < min_interval) begin
               r.status = ST_SHORT;
            end else begin
               slot_single[next_free] = w.one_shot;
               slot_held[next_free]   = 1'b0;
               slot_tick[next_free]   = 1'b0;
               slot_period[next_free] = w.interval;
               slot_left[next_free]   = w.interval;
               slot_live[next_free]   = 1'b1;
               r.new_id               = next_free[3:0];
               next_free              = next_free + 1'b1;
            end
         end
         OP_SET_PAUSE: begin
            if (!slot_live[id]) r.status = ST_NO_TIMER;
            else slot_held[id] = w.pause_value;
         end
         OP_READ_TICK: begin
            if (!slot_live[id]) begin
               r.status = ST_NO_TIMER;
            end else if (!slot_held[id] && slot_tick[id]) begin
               slot_tick[id] = 1'b0;
               r.ticked      = 1'b1;
               if (slot_single[id]) slot_live[id] = 1'b0;
            end
         end
         OP_READ_PAUSE: begin
            if (!slot_live[id]) r.status = ST_NO_TIMER;
            else r.is_paused = slot_held[id];
         end
         OP_ADVANCE: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (slot_live[s] && !slot_held[s]) age_slot(s, w.elapsed);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_live[s]   = 1'b0;
            slot_single[s] = 1'b0;
            slot_held[s]   = 1'b0;
            slot_tick[s]   = 1'b0;
            slot_period[s] = '0;
            slot_left[s]   = '0;
         end
         next_free     = '0;
         min_interval  = 32'd1;
         answer_q.delete();
         fail_count    = 0;
         words_checked = 0;
         ticks_seen    = 0;
      end else begin
         if (csr_wr_en) min_interval = csr_wr_data;
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               $error("response word with no request waiting: %p", rsp_word);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               words_checked++;
               if (rsp_word.ticked === 1'b1) ticks_seen++;
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  fail_count++;
               end
               if (rsp_word.new_id !== want.new_id) begin
                  $error("new_id: expected %0d, got %0d", want.new_id, rsp_word.new_id);
                  fail_count++;
               end
               if (rsp_word.ticked !== want.ticked) begin
                  $error("ticked: expected %0d, got %0d", want.ticked, rsp_word.ticked);
                  fail_count++;
               end
               if (rsp_word.is_paused !== want.is_paused) begin
                  $error("is_paused: expected %0d, got %0d", want.is_paused,
                         rsp_word.is_paused);
                  fail_count++;
               end
            end
         end
         // A new word can be taken on the edge that delivers the previous answer.
         if (start && !busy) answer_q.push_back(predict_answer(req_word));
      end
      pending_words = answer_q.size();
   end

endmodule

### verif/testbench.sv
// Top level of the timer bank testbench: clock, reset, request stimulus and verdict.
// Depends on tbpo_pkg, the block timer_bank_periodic_oneshot_unit and tbpo_answer_check.
// The checker beside the block predicts and compares; this module only drives and reports.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tbpo_pkg::*;

   // Operation codes the block must ignore.
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
   // Chance in percent that the sender idles before a word.
   localparam int GAP_PERCENT   = 27;
   localparam int PHASE_WORDS   = 150;
   localparam int PHASE_COUNT   = 5;
   // Longest advance walks all sixteen slots with a reload each.
   localparam int SETTLE_CYCLES = 400;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic                 busy;
   req_type              req_word    = '0;
   logic                 rsp_valid;
   rsp_type              rsp_word;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_WIDTH-1:0] csr_wr_data = '0;

   int          fail_count;
   int          pending_words;
   int          words_checked;
   int          ticks_seen;
   int          op_count [8];
   int          floor_writes;
   bit          gaps_on     = 1'b1;
   logic [31:0] floor_now   = 32'd1;

   always #5 clock = ~clock;

   timer_bank_periodic_oneshot_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tbpo_answer_check answer_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_word      (rsp_word),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .ticks_seen    (ticks_seen)
   );

   // The slowest correct run is roughly 800 words, each at worst a longest advance, near
   // 2.5 ms; the limit leaves more than five times that.
   initial begin
      #15_000_000;
      $display("[timer_bank_periodic_oneshot_unit] ERROR");
      $finish;
   end

   // All driving happens in the time step of a falling edge. On entry start either
   // is low or still holds the previous word; it is raised at most once per step.
   // Busy only moves on rising edges, so reading it at the falling edge tells
   // whether the coming rising edge takes the word.
   task automatic drive_word(req_type w);
      if (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      while (busy) @(negedge clock);
      @(negedge clock);
      op_count[w.operation]++;
   endtask

   // Stops sending and waits until every predicted response has come back. It
   // always waits for a falling edge, so start is never lowered and raised in one step.
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
   endtask

   // Every word answers once, so an empty prediction queue means the block is idle
   // and the minimum interval can be changed safely.
   task automatic write_floor(logic [31:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      floor_now    = value;
      floor_writes++;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic issue(logic [2:0] op, logic [3:0] id, logic [31:0] iv, logic single,
                        logic hold, logic [ELAPSED_WIDTH-1:0] el);
      req_type w;
      w.operation   = op;
      w.timer_id    = id;
      w.interval    = iv;
      w.one_shot    = single;
      w.pause_value = hold;
      w.elapsed     = el;
      drive_word(w);
   endtask

   // Random word: every field gets random bits, then the fields that matter for
   // the chosen operation are shaped so that timers start, run and tick often.
   function automatic req_type random_word();
      req_type w;
      int      pick;
      w.timer_id    = 4'($urandom_range(0, 15));
      w.interval    = $urandom;
      w.one_shot    = 1'($urandom_range(0, 1));
      w.pause_value = 1'($urandom_range(0, 1));
      w.elapsed     = 16'($urandom);
      pick          = $urandom_range(0, 99);
      if (pick < 8) begin
         w.operation = OP_START;
         case ($urandom_range(0, 5))
            0: w.interval = floor_now;
            1: w.interval = floor_now - 1;
            2: ;
            default: w.interval = $urandom_range(0, 300);
         endcase
      end else if (pick < 22) begin
         // Mostly release, so that most timers keep running.
         w.operation   = OP_SET_PAUSE;
         w.pause_value = ($urandom_range(0, 99) < 35);
      end else if (pick < 52) begin
         w.operation = OP_READ_TICK;
      end else if (pick < 62) begin
         w.operation = OP_READ_PAUSE;
      end else if (pick < 96) begin
         w.operation = OP_ADVANCE;
         if ($urandom_range(0, 9) != 0) w.elapsed = 16'($urandom_range(0, 120));
      end else begin
         w.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end
      return w;
   endfunction

   initial begin
      logic [31:0] floors [PHASE_COUNT];
      floors[0] = 32'hFFFF_FFFF;
      floors[1] = 32'd20;
      floors[2] = $urandom_range(0, 500);
      floors[3] = 32'd1;
      floors[4] = 32'd0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, starting from the reset minimum interval of one.
      // Queries of slots that were never started must report no such timer.
      issue(OP_READ_PAUSE, 4'd0, '0, 1'b0, 1'b0, '0);
      issue(OP_SET_PAUSE, 4'd15, '0, 1'b0, 1'b1, '0);
      issue(OP_READ_TICK, 4'd3, '0, 1'b0, 1'b0, '0);
      // An interval below the minimum is refused and uses no slot id.
      issue(OP_START, 4'd0, 32'd0, 1'b0, 1'b0, '0);
      issue(OP_START, 4'd0, 32'd1, 1'b0, 1'b0, '0);
      issue(OP_START, 4'd0, 32'd10, 1'b1, 1'b0, '0);
      issue(OP_START, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
      // Slot 0 reloads many times, slot 1 lands exactly on zero and must not tick.
      issue(OP_ADVANCE, 4'd0, '0, 1'b0, 1'b0, 16'd10);
      issue(OP_READ_TICK, 4'd1, '0, 1'b0, 1'b0, '0);
      issue(OP_ADVANCE, 4'd0, '0, 1'b0, 1'b0, 16'd1);
      // A paused one-shot timer hides its pending tick and keeps it.
      issue(OP_SET_PAUSE, 4'd1, '0, 1'b0, 1'b1, '0);
      issue(OP_READ_TICK, 4'd1, '0, 1'b0, 1'b0, '0);
      issue(OP_READ_PAUSE, 4'd1, '0, 1'b0, 1'b0, '0);
      issue(OP_SET_PAUSE, 4'd1, '0, 1'b0, 1'b0, '0);
      // Consuming the tick retires the one-shot timer; a second read finds no timer.
      issue(OP_READ_TICK, 4'd1, '0, 1'b0, 1'b0, '0);
      issue(OP_READ_TICK, 4'd1, '0, 1'b0, 1'b0, '0);
      issue(OP_READ_TICK, 4'd0, '0, 1'b0, 1'b0, '0);
      issue(OP_ADVANCE, 4'd0, '0, 1'b0, 1'b0, 16'hFFFF);
      issue(OP_FIRST_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
      issue(OP_LAST_UNUSED, 4'd0, '0, 1'b0, 1'b0, '0);
      // With no minimum a zero period is allowed: it ticks once and sticks at zero.
      write_floor(32'd0);
      issue(OP_START, 4'd0, 32'd0, 1'b1, 1'b0, '0);
      issue(OP_ADVANCE, 4'd0, '0, 1'b0, 1'b0, 16'd0);
      issue(OP_ADVANCE, 4'd0, '0, 1'b0, 1'b0, 16'd5);
      issue(OP_READ_TICK, 4'd3, '0, 1'b0, 1'b0, '0);

      // Random part, one phase per minimum-interval setting. The bank fills up
      // along the way, after which starts report a full bank. The middle phase
      // sends back to back with no idle cycles at all.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_floor(floors[p]);
         gaps_on = (p != 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (gaps_on && $urandom_range(0, 99) < 2) settle();
            drive_word(random_word());
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d checked words under %0d minimum-interval settings.",
               words_checked, floor_writes);
      $display("Sent %0d starts, %0d advances, %0d tick reads; %0d ticks were consumed.",
               op_count[OP_START], op_count[OP_ADVANCE], op_count[OP_READ_TICK],
               ticks_seen);
      if (fail_count == 0 && pending_words == 0) begin
         $display("[timer_bank_periodic_oneshot_unit] OK");
      end else begin
         $display("[timer_bank_periodic_oneshot_unit] ERROR");
      end
      $finish;
   end

endmodule
